### src/sdh_pkg.sv
// ----------------------------------------------------------------------------
// SD card SPI host package
// Shared types, widths and defaults for the SD card SPI host engine.
// ----------------------------------------------------------------------------
package sdh_pkg;

   // Default sizes of a data block, a card register and the response poll
   localparam int BLOCK_BYTES_DEF    = 512;
   localparam int REGISTER_BYTES_DEF = 16;
   localparam int RESPONSE_TRIES_DEF = 20;

   // Fixed field widths
   localparam int REQ_W    = 3;
   localparam int CMD_W    = 6;
   localparam int ARG_W    = 32;
   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 2;
   localparam int POLL_W   = 5;

   // Completion codes reported with each result beat
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_R1_ERROR = 2'd1;
   localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd2;
   localparam logic [STATUS_W-1:0] ST_IGNORED  = 2'd3;

   // One request beat
   typedef struct packed {
      logic [BYTE_W-1:0] write_byte;
      logic [BYTE_W-1:0] miso_byte;
      logic [ARG_W-1:0]  argument;
      logic [CMD_W-1:0]  cmd_index;
      logic [REQ_W-1:0]  req_type;
   } sdh_item_type;

   // One result beat
   typedef struct packed {
      logic [BYTE_W-1:0]   response;
      logic [STATUS_W-1:0] status;
      logic                done_res;
      logic                write_taken;
      logic [BYTE_W-1:0]   read_data;
      logic                read_valid;
      logic                card_selected;
      logic [BYTE_W-1:0]   mosi_byte;
   } sdh_result_type;

endpackage

### src/sdh_engine.sv
// ----------------------------------------------------------------------------
// SD card SPI host sequencer
// Holds the transfer state and computes one result per request beat.
// ----------------------------------------------------------------------------
module sdh_engine
   import sdh_pkg::*;
#(
   parameter int BLOCK_BYTES    = BLOCK_BYTES_DEF,
   parameter int REGISTER_BYTES = REGISTER_BYTES_DEF,
   parameter int RESPONSE_TRIES = RESPONSE_TRIES_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           step_en,
   input  sdh_item_type   item,
   output sdh_result_type res
);

   localparam int MAX_BYTES = (BLOCK_BYTES > REGISTER_BYTES) ? BLOCK_BYTES : REGISTER_BYTES;
   localparam int CNT_W     = $clog2(MAX_BYTES + 1);

   localparam logic [CNT_W:0]    BLOCK_LEN = (CNT_W+1)'(BLOCK_BYTES);
   localparam logic [CNT_W:0]    REG_LEN   = (CNT_W+1)'(REGISTER_BYTES);
   localparam logic [POLL_W-1:0] TRIES     = POLL_W'(RESPONSE_TRIES);

   // Request codes
   localparam logic [REQ_W-1:0] REQ_XFER  = 3'd0;
   localparam logic [REQ_W-1:0] REQ_CMD   = 3'd1;
   localparam logic [REQ_W-1:0] REQ_READ  = 3'd2;
   localparam logic [REQ_W-1:0] REQ_WRITE = 3'd3;
   localparam logic [REQ_W-1:0] REQ_REG   = 3'd4;

   // Command numbers and bytes on the wire
   localparam logic [CMD_W-1:0]  CMD_GO_IDLE   = 6'd0;
   localparam logic [CMD_W-1:0]  CMD_SEND_IF   = 6'd8;
   localparam logic [CMD_W-1:0]  CMD_RD_SINGLE = 6'd17;
   localparam logic [CMD_W-1:0]  CMD_WR_SINGLE = 6'd24;
   localparam logic [BYTE_W-1:0] BYTE_IDLE     = 8'hFF;
   localparam logic [BYTE_W-1:0] START_TOKEN   = 8'hFE;
   localparam logic [BYTE_W-1:0] CRC_CMD0      = 8'h95;
   localparam logic [BYTE_W-1:0] CRC_CMD8      = 8'h87;
   localparam logic [1:0]        FRAME_PREFIX  = 2'b01;
   localparam logic [4:0]        DATA_ACCEPTED = 5'h05;
   localparam logic [CNT_W-1:0]  FRAME_LAST    = CNT_W'(5);
   localparam logic [CNT_W-1:0]  TAIL_BYTES    = CNT_W'(2);

   typedef enum logic [3:0] {
      PH_IDLE, PH_READY, PH_FRAME, PH_POLL, PH_TOKEN, PH_RDATA,
      PH_RCRC, PH_WTOKEN, PH_WDATA, PH_WTAIL, PH_WBUSY
   } phase_type;

   typedef enum logic [1:0] {
      OP_CMD, OP_READ, OP_WRITE, OP_REG
   } op_type;

   phase_type          phase_ff, phase_in;
   op_type             op_ff, op_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [POLL_W-1:0]  poll_ff, poll_in;
   logic [CMD_W-1:0]   cmd_ff, cmd_in;
   logic [ARG_W-1:0]   arg_ff, arg_in;
   logic [BYTE_W-1:0]  r1_ff, r1_in;
   logic               cs_ff, cs_in;
   logic [BYTE_W-1:0]  tx_ff, tx_in;

   logic [CNT_W:0]     cnt_next;
   logic [CNT_W:0]     read_len;

   // Byte of the six-byte command frame at a given position
   function automatic logic [BYTE_W-1:0] frame_byte(input logic [CMD_W-1:0] cmd,
                                                    input logic [ARG_W-1:0] arg,
                                                    input logic [2:0]       pos);
      logic [BYTE_W-1:0] b;
      case (pos)
         3'd0:    b = {FRAME_PREFIX, cmd};
         3'd1:    b = arg[31:24];
         3'd2:    b = arg[23:16];
         3'd3:    b = arg[15:8];
         3'd4:    b = arg[7:0];
         default: begin
            if (cmd == CMD_GO_IDLE) begin
               b = CRC_CMD0;
            end else if (cmd == CMD_SEND_IF) begin
               b = CRC_CMD8;
            end else begin
               b = BYTE_IDLE;
            end
         end
      endcase
      return b;
   endfunction

   assign cnt_next = {1'b0, cnt_ff} + (CNT_W+1)'(1);
   assign read_len = (op_ff == OP_READ) ? BLOCK_LEN : REG_LEN;

   // Next state and result for the current request beat
   always_comb begin
      phase_in = phase_ff;
      op_in    = op_ff;
      cnt_in   = cnt_ff;
      poll_in  = poll_ff;
      cmd_in   = cmd_ff;
      arg_in   = arg_ff;
      r1_in    = r1_ff;
      cs_in    = cs_ff;
      tx_in    = tx_ff;

      res.read_valid  = 1'b0;
      res.read_data   = '0;
      res.write_taken = 1'b0;
      res.done_res    = 1'b0;
      res.status      = ST_OK;

      if (item.req_type != REQ_XFER) begin
         // A new request starts only when the sequencer is idle
         if (item.req_type <= REQ_REG && phase_ff == PH_IDLE) begin
            unique case (item.req_type)
               REQ_CMD: begin
                  op_in  = OP_CMD;
                  cmd_in = item.cmd_index;
                  arg_in = item.argument;
               end
               REQ_READ: begin
                  op_in  = OP_READ;
                  cmd_in = CMD_RD_SINGLE;
                  arg_in = item.argument;
               end
               REQ_WRITE: begin
                  op_in  = OP_WRITE;
                  cmd_in = CMD_WR_SINGLE;
                  arg_in = item.argument;
               end
               default: begin
                  op_in  = OP_REG;
                  cmd_in = item.cmd_index;
                  arg_in = '0;
               end
            endcase
            cs_in    = 1'b1;
            phase_in = PH_READY;
            cnt_in   = '0;
            poll_in  = '0;
            tx_in    = BYTE_IDLE;
         end else begin
            res.status = ST_IGNORED;
         end
      end else begin
         unique case (phase_ff)
            // Wait for the card to release the bus
            PH_READY: begin
               tx_in = BYTE_IDLE;
               if (item.miso_byte == BYTE_IDLE) begin
                  phase_in = PH_FRAME;
                  cnt_in   = '0;
                  tx_in    = frame_byte(cmd_ff, arg_ff, 3'd0);
               end
            end
            // Command frame, one byte per exchange
            PH_FRAME: begin
               if (cnt_ff < FRAME_LAST) begin
                  cnt_in = cnt_next[CNT_W-1:0];
                  tx_in  = frame_byte(cmd_ff, arg_ff, cnt_next[2:0]);
               end else begin
                  phase_in = PH_POLL;
                  poll_in  = '0;
                  tx_in    = BYTE_IDLE;
               end
            end
            // Poll for the R1 response
            PH_POLL: begin
               poll_in = poll_ff + POLL_W'(1);
               tx_in   = BYTE_IDLE;
               if (!item.miso_byte[7] || poll_in >= TRIES) begin
                  r1_in = item.miso_byte;
                  if (op_ff == OP_CMD) begin
                     phase_in     = PH_IDLE;
                     res.done_res = 1'b1;
                     res.status   = (item.miso_byte != '0) ? ST_R1_ERROR : ST_OK;
                  end else if (item.miso_byte != '0) begin
                     phase_in     = PH_IDLE;
                     cs_in        = 1'b0;
                     res.done_res = 1'b1;
                     res.status   = ST_R1_ERROR;
                  end else if (op_ff == OP_WRITE) begin
                     phase_in = PH_WTOKEN;
                     tx_in    = START_TOKEN;
                  end else begin
                     phase_in = PH_TOKEN;
                  end
               end
            end
            // Skip idle bytes until the data token
            PH_TOKEN: begin
               tx_in = BYTE_IDLE;
               if (item.miso_byte != BYTE_IDLE) begin
                  phase_in = PH_RDATA;
                  cnt_in   = '0;
               end
            end
            // Pass payload bytes out
            PH_RDATA: begin
               res.read_valid = 1'b1;
               res.read_data  = item.miso_byte;
               tx_in          = BYTE_IDLE;
               if (cnt_next >= read_len) begin
                  phase_in = PH_RCRC;
                  cnt_in   = '0;
               end else begin
                  cnt_in = cnt_next[CNT_W-1:0];
               end
            end
            // Drop the two CRC bytes
            PH_RCRC: begin
               tx_in = BYTE_IDLE;
               if (cnt_ff == '0) begin
                  cnt_in = CNT_W'(1);
               end else begin
                  phase_in     = PH_IDLE;
                  res.done_res = 1'b1;
                  if (op_ff == OP_READ) begin
                     cs_in = 1'b0;
                  end
               end
            end
            PH_WTOKEN: begin
               phase_in        = PH_WDATA;
               cnt_in          = '0;
               tx_in           = item.write_byte;
               res.write_taken = 1'b1;
            end
            // Payload bytes of a block write
            PH_WDATA: begin
               if (cnt_next < BLOCK_LEN) begin
                  cnt_in          = cnt_next[CNT_W-1:0];
                  tx_in           = item.write_byte;
                  res.write_taken = 1'b1;
               end else begin
                  phase_in = PH_WTAIL;
                  cnt_in   = '0;
                  tx_in    = BYTE_IDLE;
               end
            end
            // Dummy CRC bytes, then the data response
            PH_WTAIL: begin
               tx_in = BYTE_IDLE;
               if (cnt_ff < TAIL_BYTES) begin
                  cnt_in = cnt_next[CNT_W-1:0];
               end else if (item.miso_byte[4:0] != DATA_ACCEPTED) begin
                  phase_in     = PH_IDLE;
                  cs_in        = 1'b0;
                  res.done_res = 1'b1;
                  res.status   = ST_REJECTED;
               end else begin
                  phase_in = PH_WBUSY;
               end
            end
            // Card busy programming the block
            PH_WBUSY: begin
               tx_in = BYTE_IDLE;
               if (item.miso_byte == BYTE_IDLE) begin
                  phase_in     = PH_IDLE;
                  cs_in        = 1'b0;
                  res.done_res = 1'b1;
               end
            end
            default: begin
               phase_in = PH_IDLE;
               tx_in    = BYTE_IDLE;
            end
         endcase
      end

      res.mosi_byte     = tx_in;
      res.card_selected = cs_in;
      res.response      = r1_in;
   end

   // State registers advance once per processed beat
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         op_ff    <= OP_CMD;
         cnt_ff   <= '0;
         poll_ff  <= '0;
         cmd_ff   <= '0;
         arg_ff   <= '0;
         r1_ff    <= BYTE_IDLE;
         cs_ff    <= 1'b0;
         tx_ff    <= BYTE_IDLE;
      end else if (step_en) begin
         phase_ff <= phase_in;
         op_ff    <= op_in;
         cnt_ff   <= cnt_in;
         poll_ff  <= poll_in;
         cmd_ff   <= cmd_in;
         arg_ff   <= arg_in;
         r1_ff    <= r1_in;
         cs_ff    <= cs_in;
         tx_ff    <= tx_in;
      end
   end

   // A finished request always leaves the sequencer idle
   assert property (@(posedge clock) disable iff (reset)
      step_en && res.done_res |=> phase_ff == PH_IDLE)
      else $error("sdh_engine: done without return to idle");

   // Payload bytes come out only in the read data phase
   assert property (@(posedge clock) disable iff (reset)
      step_en && res.read_valid |-> phase_ff == PH_RDATA)
      else $error("sdh_engine: read byte outside data phase");

   // Write bytes are consumed only after the start token
   assert property (@(posedge clock) disable iff (reset)
      step_en && res.write_taken |-> phase_ff == PH_WTOKEN || phase_ff == PH_WDATA)
      else $error("sdh_engine: write byte taken outside data phase");

   // An ignored request leaves the phase untouched
   assert property (@(posedge clock) disable iff (reset)
      step_en && res.status == ST_IGNORED |=> phase_ff == $past(phase_ff))
      else $error("sdh_engine: ignored request changed phase");

endmodule

### src/sd_card_spi_host_engine_top.sv
// ----------------------------------------------------------------------------
// SD card SPI host engine, top level
// Stream wrapper with request and result registers around the sequencer.
// ----------------------------------------------------------------------------
// Each request beat on req_ is either a new transfer request (command, block
// read, block write or register read) or the report of one finished SPI byte
// exchange carrying the byte received from the card. Every request beat
// yields exactly one result beat on rsp_, with the byte to send next, the
// chip select level, any payload byte read, whether write_byte was used,
// and completion status.
// A result beat passes through the request register and then the result
// register before it is presented. Throughput is one beat per clock while
// results are taken; the sequencer state update is a single step of logic
// between the two registers.
// When rsp_tready is low the result register holds its beat, the request
// register holds one more beat, and req_tready then drops until the
// result is taken. No beat is lost or repeated.
// Reset (synchronous, active high) empties both registers, returns the
// sequencer to idle with the card deselected, and sets the last response
// byte to 0xFF.
// ----------------------------------------------------------------------------
module sd_card_spi_host_engine_top
   import sdh_pkg::*;
#(
   parameter int BLOCK_BYTES    = BLOCK_BYTES_DEF,
   parameter int REGISTER_BYTES = REGISTER_BYTES_DEF,
   parameter int RESPONSE_TRIES = RESPONSE_TRIES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // cmd_index[5:0], argument[37:6], miso_byte[45:38], write_byte[53:46]
   input  logic [55:0] req_tdata,
   // req_type[2:0]
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // mosi_byte[7:0], card_selected[8], read_valid[9], read_data[17:10],
   // write_taken[18], done_res[19], status[21:20], response[29:22]
   output logic [31:0] rsp_tdata
);

   logic           in_valid_ff;
   sdh_item_type   in_item_ff;
   logic           out_valid_ff;
   sdh_result_type out_res_ff;
   sdh_result_type step_res;
   logic           step_en;

   // Process the held beat when the result register is free or draining
   assign step_en    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step_en;

   // Request register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff.req_type   <= req_tuser;
         in_item_ff.cmd_index  <= req_tdata[5:0];
         in_item_ff.argument   <= req_tdata[37:6];
         in_item_ff.miso_byte  <= req_tdata[45:38];
         in_item_ff.write_byte <= req_tdata[53:46];
      end
   end

   sdh_engine #(
      .BLOCK_BYTES    (BLOCK_BYTES),
      .REGISTER_BYTES (REGISTER_BYTES),
      .RESPONSE_TRIES (RESPONSE_TRIES)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .item    (in_item_ff),
      .res     (step_res)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step_en) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         out_res_ff <= step_res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_res_ff};

endmodule
